// ===== src/gcr_pkg.sv =====
`default_nettype none
package gcr_pkg;

  localparam int unsigned DefTableIndexBits = 8;

  localparam logic [16:0] ONE_Q16 = 17'h10000;
  localparam logic [63:0] ONE_Q30 = 64'h4000_0000;

  // register indexes of the write port
  localparam logic [1:0] REG_VALUE_MIN     = 2'd0;
  localparam logic [1:0] REG_INVERSE_SPAN  = 2'd1;
  localparam logic [1:0] REG_GAMMA_CONTROL = 2'd2;

  localparam logic [31:0] RST_VALUE_MIN     = 32'd0;
  localparam logic [31:0] RST_INVERSE_SPAN  = 32'd16777216;
  localparam logic [16:0] RST_GAMMA_CONTROL = 17'd32768;

  // color and flag riding along the pipeline
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       clamped;
  } side_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] b;
    x = x_in;
    r = '0;
    b = 64'd1 << 62;
    for (int s = 0; s < 32; s++) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // log2(1 + i/2^k), Q0.16, square-and-compare
  function automatic logic [15:0] log_entry(input int i, input int k);
    logic [63:0] x;
    logic [15:0] res;
    x = ONE_Q30 + (64'(i) << (30 - k));
    res = '0;
    for (int s = 0; s < 16; s++) begin
      x = (x * x) >> 30;
      if (x >= 2 * ONE_Q30) begin
        x = x >> 1;
        res[15 - s] = 1'b1;
      end
    end
    return res;
  endfunction

  // 2^(-j/2^k), Q1.30
  function automatic logic [30:0] exp_entry(input int j, input int k);
    logic [63:0] c [1:12];
    logic [63:0] acc;
    acc = ONE_Q30;
    c[1] = isqrt64(64'd1 << 59);
    for (int m = 1; m < 12; m++) c[m + 1] = isqrt64(c[m] << 30);
    for (int b = 0; b < k; b++) begin
      if (((j >> b) & 1) != 0) acc = (acc * c[k - b]) >> 30;
    end
    return acc[30:0];
  endfunction

endpackage
`default_nettype wire

// ===== src/gamma_color_ramp.sv =====
// Throughput: one item per cycle when not stalled; set by the 7-stage pipeline
//   (subtract, scale multiply, clamp, log lookup, gamma multiply, exp, blend).
// Reset (rst, synchronous): clears all stage valid bits and loads the
//   registers with their defaults (min 0, inverse span 1.0, control 0.5).
`default_nettype none
module gamma_color_ramp
  import gcr_pkg::*;
#(
  parameter int unsigned POW_TABLE_INDEX_BITS = DefTableIndexBits
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] value,
  input  wire logic [7:0]  base_red,
  input  wire logic [7:0]  base_green,
  input  wire logic [7:0]  base_blue,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic             clamped
);

  localparam int unsigned K       = POW_TABLE_INDEX_BITS;
  localparam int unsigned TblSize = 1 << K;

  // ---------------- configuration ----------------
  logic [31:0] value_min;
  logic [31:0] inverse_span;
  logic [16:0] gamma_control;

  always_ff @(posedge clk) begin
    if (rst) begin
      value_min     <= RST_VALUE_MIN;
      inverse_span  <= RST_INVERSE_SPAN;
      gamma_control <= RST_GAMMA_CONTROL;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VALUE_MIN:     value_min     <= cfg_data;
        REG_INVERSE_SPAN:  inverse_span  <= cfg_data;
        REG_GAMMA_CONTROL: gamma_control <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // gamma = 8 * control, Q4.16
  logic [19:0] gamma;
  assign gamma = {gamma_control, 3'b000};

  // ---------------- constant tables ----------------
  logic [15:0] log_tbl [TblSize];
  logic [30:0] exp_tbl [TblSize];
  for (genvar gi = 0; gi < TblSize; gi++) begin : g_tbl
    assign log_tbl[gi] = log_entry(gi, K);
    assign exp_tbl[gi] = exp_entry(gi, K);
  end

  // ---------------- flow control ----------------
  // Each stage moves when it is empty or the next one moves; the output
  // register is the last stage.
  logic v1, v2, v3, v4, v5, v6;
  logic adv1, adv2, adv3, adv4, adv5, adv6, adv7;
  assign adv7 = !out_valid || !out_stall;
  assign adv6 = !v6 || adv7;
  assign adv5 = !v5 || adv6;
  assign adv4 = !v4 || adv5;
  assign adv3 = !v3 || adv4;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign in_stall = !adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
      v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
      if (adv5) v5 <= v4;
      if (adv6) v6 <= v5;
      if (adv7) out_valid <= v6;
    end
  end

  // ---------------- stage 1: offset ----------------
  logic [32:0] d1;
  side_t       side1;
  always_ff @(posedge clk) begin
    if (adv1) begin
      d1    <= {value[31], value} - {value_min[31], value_min};
      side1 <= '{red: base_red, green: base_green, blue: base_blue, clamped: 1'b0};
    end
  end

  // ---------------- stage 2: scale by inverse span ----------------
  logic        neg2;
  logic [47:0] hi2;
  logic [31:0] lo2;
  logic [47:0] lo_prod;
  side_t       side2;
  assign lo_prod = d1[31:0] * inverse_span[15:0];
  always_ff @(posedge clk) begin
    if (adv2) begin
      neg2  <= d1[32];
      hi2   <= d1[31:0] * inverse_span[31:16];
      lo2   <= lo_prod[47:16];
      side2 <= side1;
    end
  end

  // ---------------- stage 3: truncate and clamp ----------------
  logic [48:0] sum3;
  logic [24:0] tr3;
  logic [16:0] t_next;
  logic        cl_next;
  logic [16:0] t3;
  side_t       side3;
  assign sum3 = {1'b0, hi2} + {17'd0, lo2};
  assign tr3  = sum3[48:24];
  always_comb begin
    if (neg2) begin
      t_next  = '0;
      cl_next = 1'b1;
    end else if (tr3 > {8'd0, ONE_Q16}) begin
      t_next  = ONE_Q16;
      cl_next = 1'b1;
    end else begin
      t_next  = tr3[16:0];
      cl_next = 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (adv3) begin
      t3    <= t_next;
      side3 <= '{red: side2.red, green: side2.green, blue: side2.blue, clamped: cl_next};
    end
  end

  // ---------------- stage 4: -log2 t ----------------
  logic [3:0]   q4;
  logic [15:0]  norm4;
  logic [K-1:0] idx4;
  logic [20:0]  nl_next;
  logic         force_next, one_next;
  always_comb begin
    q4 = '0;
    for (int b = 0; b < 16; b++) begin
      if (t3[b]) q4 = 4'(b);
    end
    norm4   = t3[15:0] << (4'd15 - q4);
    idx4    = norm4[14 -: K];
    nl_next = ({17'd0, 4'd0 - q4} << 16) - {5'd0, log_tbl[idx4]};
    if (q4 == 4'd0) nl_next = 21'h10_0000 - {5'd0, log_tbl[idx4]};
    // gamma zero or full t gives one; zero t gives zero unless gamma is zero
    force_next = (gamma == '0) || (t3 == '0) || t3[16];
    one_next   = (gamma == '0) || t3[16];
  end

  logic [20:0] nl4;
  logic        force4, one4;
  side_t       side4;
  always_ff @(posedge clk) begin
    if (adv4) begin
      nl4    <= nl_next;
      force4 <= force_next;
      one4   <= one_next;
      side4  <= side3;
    end
  end

  // ---------------- stage 5: times gamma ----------------
  logic [40:0] gprod;
  logic [24:0] y5;
  logic        force5, one5;
  side_t       side5;
  assign gprod = gamma * nl4;
  always_ff @(posedge clk) begin
    if (adv5) begin
      y5     <= gprod[40:16];
      force5 <= force4;
      one5   <= one4;
      side5  <= side4;
    end
  end

  // ---------------- stage 6: exp2 ----------------
  logic [K-1:0] j6;
  logic [9:0]   sh6;
  logic [30:0]  shifted6;
  logic [16:0]  p_next;
  assign j6       = y5[15 -: K];
  assign sh6      = {1'b0, y5[24:16]} + 10'd14;
  assign shifted6 = exp_tbl[j6] >> sh6[4:0];
  always_comb begin
    if (force5)            p_next = one5 ? ONE_Q16 : '0;
    else if (sh6 >= 10'd31) p_next = '0;
    else                   p_next = shifted6[16:0];
  end

  logic [16:0] p6;
  side_t       side6;
  always_ff @(posedge clk) begin
    if (adv6) begin
      p6    <= p_next;
      side6 <= side5;
    end
  end

  // ---------------- stage 7: blend toward white ----------------
  function automatic logic [7:0] blend(input logic [16:0] p, input logic [7:0] base);
    logic [25:0] prod;
    prod = 26'(p) * 26'(8'd255 - base) + 26'd65535;
    return 8'd255 - prod[23:16];
  endfunction

  always_ff @(posedge clk) begin
    if (adv7) begin
      out_red   <= blend(p6, side6.red);
      out_green <= blend(p6, side6.green);
      out_blue  <= blend(p6, side6.blue);
      clamped   <= side6.clamped;
    end
  end

`ifndef SYNTH
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output free");
  a_t_in_range: assert property (@(posedge clk) disable iff (rst)
    v3 |-> (t3 <= ONE_Q16))
    else $error("t above one");
  a_nl_positive: assert property (@(posedge clk) disable iff (rst)
    (v4 && !force4) |-> (nl4 != '0))
    else $error("zero log for t below one");
  a_p_in_range: assert property (@(posedge clk) disable iff (rst)
    v6 |-> (p6 <= ONE_Q16))
    else $error("power above one");
`endif

endmodule
`default_nettype wire

// ===== tb/gcr_checker.sv =====
`default_nettype none
module gcr_checker
  import gcr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [31:0] value,
  input  wire logic [7:0]  base_red,
  input  wire logic [7:0]  base_green,
  input  wire logic [7:0]  base_blue,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [7:0]  out_red,
  input  wire logic [7:0]  out_green,
  input  wire logic [7:0]  out_blue,
  input  wire logic        clamped,
  output int               fail_count,
  output int               pending
);

  localparam int K = 8;

  logic [31:0] min_r;
  logic [31:0] ispan_r;
  logic [16:0] ctrl_r;
  logic [15:0] log_tab [0:255];
  logic [30:0] exp_tab [0:255];
  // expected items, ring buffer
  side_t       exp_mem [0:1023];
  int          wr_ptr;
  int          rd_ptr;

  function automatic logic [63:0] root64(input logic [63:0] xi);
    logic [63:0] x, r, b;
    x = xi;
    r = '0;
    b = 64'd1 << 62;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  initial begin
    logic [63:0] x, acc;
    logic [63:0] c [1:12];
    c[1] = root64(64'd1 << 59);
    for (int m = 1; m < 12; m++) c[m + 1] = root64(c[m] << 30);
    for (int i = 0; i < 256; i++) begin
      x = 64'h4000_0000 + (64'(i) << (30 - K));
      log_tab[i] = '0;
      for (int s = 0; s < 16; s++) begin
        x = (x * x) >> 30;
        if (x >= 64'h8000_0000) begin
          x = x >> 1;
          log_tab[i][15 - s] = 1'b1;
        end
      end
      acc = 64'h4000_0000;
      for (int b = 0; b < K; b++)
        if (i[b]) acc = (acc * c[K - b]) >> 30;
      exp_tab[i] = acc[30:0];
    end
  end

  function automatic logic [7:0] blend(input logic [16:0] p, input logic [7:0] base);
    logic [63:0] prod;
    prod = 64'(p) * (64'd255 - 64'(base));
    return 8'(64'd255 - ((prod + 64'd65535) >> 16));
  endfunction

  function automatic side_t ramp_color(input logic [31:0] v, input logic [7:0] br,
                                       input logic [7:0] bg, input logic [7:0] bb);
    logic signed [33:0] d;
    logic [63:0] tr, g, nl, y, n, e;
    logic [16:0] t, p;
    int q;
    side_t res;
    res.clamped = 1'b0;
    d = 34'(signed'(v)) - 34'(signed'(min_r));
    if (d < 0) begin
      t = '0;
      res.clamped = 1'b1;
    end else begin
      tr = ((64'(d) * 64'(ispan_r[31:16])) + ((64'(d) * 64'(ispan_r[15:0])) >> 16)) >> 24;
      if (tr > 64'h10000) begin
        t = 17'h10000;
        res.clamped = 1'b1;
      end else begin
        t = tr[16:0];
      end
    end
    g = 64'(ctrl_r) * 8;
    if (g == 0) p = 17'h10000;
    else if (t == 0) p = '0;
    else if (t[16]) p = 17'h10000;
    else begin
      q = 15;
      while (!t[q]) q--;
      nl = 64'(16 - q) * 65536 - 64'(log_tab[8'((t << (15 - q)) >> (15 - K))]);
      y = (g * nl) >> 16;
      n = y >> 16;
      e = 64'(exp_tab[y[15:16-K]]);
      p = (14 + n >= 64) ? 17'd0 : 17'(e >> (14 + n));
    end
    res.red = blend(p, br);
    res.green = blend(p, bg);
    res.blue = blend(p, bb);
    return res;
  endfunction

  assign pending = wr_ptr - rd_ptr;

  always @(posedge clk) begin
    side_t exp_c;
    if (rst) begin
      min_r <= RST_VALUE_MIN;
      ispan_r <= RST_INVERSE_SPAN;
      ctrl_r <= RST_GAMMA_CONTROL;
      wr_ptr <= 0;
      rd_ptr <= 0;
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_VALUE_MIN: min_r <= cfg_data;
          REG_INVERSE_SPAN: ispan_r <= cfg_data;
          REG_GAMMA_CONTROL: ctrl_r <= cfg_data[16:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        exp_mem[wr_ptr[9:0]] <= ramp_color(value, base_red, base_green, base_blue);
        wr_ptr <= wr_ptr + 1;
      end
      if (out_valid && !out_stall) begin
        if (wr_ptr == rd_ptr) begin
          $display("%0t: unexpected item r=%0d g=%0d b=%0d c=%0d", $time,
                   out_red, out_green, out_blue, clamped);
          fail_count <= fail_count + 1;
        end else begin
          exp_c = exp_mem[rd_ptr[9:0]];
          rd_ptr <= rd_ptr + 1;
          if (exp_c != {out_red, out_green, out_blue, clamped}) begin
            $display("%0t: mismatch expected r=%0d g=%0d b=%0d c=%0d actual r=%0d g=%0d b=%0d c=%0d",
                     $time, exp_c.red, exp_c.green, exp_c.blue, exp_c.clamped,
                     out_red, out_green, out_blue, clamped);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== tb/tb_gamma_color_ramp.sv =====
`default_nettype none
module tb_gamma_color_ramp;
  import gcr_pkg::*;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] value;
  logic [7:0]  base_red, base_green, base_blue;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_red, out_green, out_blue;
  logic        clamped;
  int          fail_count;
  int          pending;
  bit          stall_on;

  gamma_color_ramp u_top (.*);

  gcr_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver: random stall stretches, sometimes none at all
  initial begin
    int w;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        w = stall_on ? $urandom_range(0, 11) : 0;
        if (w > 0) begin
          out_stall <= 1'b1;
          repeat (w) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  // one write, then the enable goes low again before the task returns
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // drain, then let the pipe settle before touching registers
  task automatic settle();
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // present one item and hold it until accepted; optional idle gap first
  task automatic send_value(input logic [31:0] v, input bit gap);
    int w;
    w = gap ? $urandom_range(0, 11) : 0;
    if (w > 0) begin
      in_valid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    in_valid <= 1'b1;
    value <= v;
    base_red <= 8'($urandom);
    base_green <= 8'($urandom);
    base_blue <= 8'($urandom);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic idle_in();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // values near the ramp window so t covers the whole 0..1 range
  function automatic logic [31:0] near_value(input logic [31:0] vmin, input logic [31:0] ispan);
    logic [63:0] span;
    span = (ispan == 0) ? 64'h10000 : ((64'd1 << 40) / 64'(ispan));
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return vmin + 32'(span);
      2: return vmin - 32'($urandom_range(1, 1000));
      3: return vmin;
      default: return vmin + 32'((64'($urandom) * (span + span / 8)) >> 32);
    endcase
  endfunction

  initial begin
    logic [31:0] vmin, ispan;
    logic [16:0] ctrl;
    logic [31:0] corner [0:5];
    bit gaps;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_VALUE_MIN;
    cfg_data = '0;
    in_valid = 1'b0;
    value = '0;
    base_red = '0;
    base_green = '0;
    base_blue = '0;
    stall_on = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset registers: zero, full, above, below, extremes, midpoints
    corner[0] = 32'h0000_0000;
    corner[1] = 32'h0001_0000;
    corner[2] = 32'h0001_0001;
    corner[3] = 32'h8000_0000;
    corner[4] = 32'h7fff_ffff;
    corner[5] = 32'h0000_0001;
    foreach (corner[i]) send_value(corner[i], 1'b0);
    send_value(32'h0000_8000, 1'b0);
    send_value(32'h0000_ffff, 1'b0);
    idle_in();
    settle();

    // gamma zero, then control above one, then control exactly one
    write_reg(REG_GAMMA_CONTROL, 32'd0);
    send_value(32'h0000_0000, 1'b0);
    send_value(32'h0000_4000, 1'b0);
    idle_in();
    settle();
    write_reg(REG_GAMMA_CONTROL, 32'h0001_ffff);
    send_value(32'h0000_0001, 1'b0);
    send_value(32'h0000_c000, 1'b0);
    idle_in();
    settle();
    write_reg(REG_GAMMA_CONTROL, 32'd65536);
    send_value(32'h0000_0001, 1'b0);
    send_value(32'h0000_c000, 1'b0);
    idle_in();
    settle();
    // zero inverse span with negative minimum extreme, then full span with positive extreme
    write_reg(REG_INVERSE_SPAN, 32'd0);
    write_reg(REG_VALUE_MIN, 32'h8000_0000);
    send_value(32'h7fff_ffff, 1'b0);
    send_value(32'h8000_0000, 1'b0);
    idle_in();
    settle();
    write_reg(REG_VALUE_MIN, 32'h7fff_ffff);
    write_reg(REG_INVERSE_SPAN, 32'hffff_ffff);
    send_value(32'h8000_0000, 1'b0);
    send_value(32'h7fff_ffff, 1'b0);
    idle_in();
    settle();

    // random phases, each with its own register setting
    stall_on = 1'b1;
    for (int ph = 0; ph < 23; ph++) begin
      vmin = $urandom;
      case ($urandom_range(0, 4))
        0: ispan = 32'h0100_0000;
        1: ispan = $urandom_range(1, 32'h00ff_ffff);
        2: ispan = $urandom;
        3: ispan = 32'($urandom_range(1, 4096)) << 20;
        default: ispan = $urandom_range(0, 3);
      endcase
      case ($urandom_range(0, 5))
        0: ctrl = 17'd0;
        1: ctrl = 17'h10000;
        2: ctrl = 17'h1ffff;
        default: ctrl = 17'($urandom_range(0, 65536));
      endcase
      write_reg(REG_VALUE_MIN, vmin);
      write_reg(REG_INVERSE_SPAN, ispan);
      write_reg(REG_GAMMA_CONTROL, 32'(ctrl));
      gaps = (ph % 4) != 1;
      stall_on = (ph % 5) != 2;
      for (int i = 0; i < 50; i++) send_value(near_value(vmin, ispan), gaps);
      idle_in();
      settle();
    end

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
src/gcr_pkg.sv
src/gamma_color_ramp.sv
tb/gcr_checker.sv
tb/tb_gamma_color_ramp.sv
